// File: design/absc_pkg.sv
// ----------------------------------------------------------------------------
// absc_pkg: shared types and helpers of the archive byte stream cipher
// Cipher state type, register indexes and constant modulo helpers.
// ----------------------------------------------------------------------------
package absc_pkg;

  localparam int unsigned KeyNoW  = 7;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;

  localparam logic [PosW-1:0] PosAStart = 4'd0;
  localparam logic [PosW-1:0] PosBStart = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_A_LOW    = 3'd0,
    REG_KEY_A_HIGH   = 3'd1,
    REG_KEY_B_LOW    = 3'd2,
    REG_KEY_B_HIGH   = 3'd3,
    REG_START_KEY_NO = 3'd4,
    REG_ENCRYPT_MODE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PosW-1:0]   pos_a;
    logic [PosW-1:0]   pos_b;
    logic [KeyNoW-1:0] key_number;
    logic              swap_flag;
  } cph_state_t;

  // Remainder by 7, using 8 = 1 mod 7 to fold the octal digits.
  function automatic logic [2:0] mod7(input logic [6:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = {2'b00, x[5:3]} + {4'b0000, x[6]} * 5'd8 + {2'b00, x[2:0]};
    t = {2'b00, s[4:3]} + {1'b0, s[2:0]};
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

  // Remainder by 3 of a five-bit value, using 4 = 1 mod 3.
  function automatic logic [1:0] mod3(input logic [4:0] y);
    logic [3:0] s;
    logic [2:0] t;
    s = {1'b0, y[4:2]} + {2'b00, y[1:0]};
    t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // Remainder by 12: the two low bits pass, the rest is taken modulo 3.
  function automatic logic [3:0] mod12(input logic [6:0] x);
    return {mod3(x[6:2]), x[1:0]};
  endfunction

endpackage

// File: design/absc_step.sv
// ----------------------------------------------------------------------------
// absc_step: one byte of the cipher
// Transforms one byte with the current state and forms the next state.
// ----------------------------------------------------------------------------
module absc_step (
  input  logic [7:0]            data_byte,
  input  logic                  encrypt_mode,
  input  logic [127:0]          key_a,
  input  logic [127:0]          key_b,
  input  absc_pkg::cph_state_t  cur,
  output logic [7:0]            result_byte,
  output absc_pkg::cph_state_t  nxt
);
  import absc_pkg::*;

  logic [7:0]        ka;
  logic [7:0]        kb;
  logic [7:0]        stage1;
  logic [7:0]        stage2;
  logic [PosW:0]     na;
  logic [PosW:0]     nb;
  logic [KeyNoW-1:0] kn_step;
  logic [3:0]        kn_mod12;
  logic [2:0]        kn_mod7;

  assign ka = key_a[{cur.pos_a, 3'b000} +: 8];
  assign kb = key_b[{cur.pos_b, 3'b000} +: 8] ^ {1'b0, cur.key_number};

  always_comb begin
    stage1 = data_byte ^ (encrypt_mode ? ka : kb);
    stage2 = cur.swap_flag ? {stage1[3:0], stage1[7:4]} : stage1;
    result_byte = stage2 ^ (encrypt_mode ? kb : ka);
  end

  assign kn_step  = cur.key_number + 7'd2;
  assign kn_mod12 = mod12(kn_step);
  assign kn_mod7  = mod7(kn_step);

  always_comb begin
    na  = {1'b0, cur.pos_a} + 5'd1;
    nb  = {1'b0, cur.pos_b} + 5'd1;
    nxt = cur;
    priority if (!na[PosW]) begin
      if (nb > 5'd12) begin
        nb            = 5'd0;
        nxt.swap_flag = ~cur.swap_flag;
      end
    end else if (nb <= 5'd8) begin
      na            = 5'd0;
      nxt.swap_flag = ~cur.swap_flag;
    end else begin
      nxt.key_number = kn_step;
      nxt.swap_flag  = ~cur.swap_flag;
      if (cur.swap_flag) begin
        na = {2'b00, kn_mod7};
        nb = {1'b0, kn_mod12} + 5'd2;
      end else begin
        na = {1'b0, kn_mod12} + 5'd3;
        nb = {2'b00, kn_mod7};
      end
    end
    nxt.pos_a = na[PosW-1:0];
    nxt.pos_b = nb[PosW-1:0];
  end

endmodule

// File: design/archive_byte_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// archive_byte_stream_cipher_core: archive byte stream cipher
// Encrypts or decrypts a byte stream with two 16-byte keys and a key number.
// ----------------------------------------------------------------------------
// The core takes one byte in every clock cycle while in_ready is high and
// returns it transformed through the output buffer. The cipher state advances
// in the same cycle as the byte is taken, so the key-position update sets the
// pace. A two-entry output buffer lets a further item enter while a result
// waits to be taken; input ready drops only when both entries are full.
module archive_byte_stream_cipher_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [absc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [absc_pkg::CfgW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte
);
  import absc_pkg::*;

  logic [63:0]       key_a_low_r;
  logic [63:0]       key_a_high_r;
  logic [63:0]       key_b_low_r;
  logic [63:0]       key_b_high_r;
  logic [KeyNoW-1:0] start_key_no_r;
  logic              encrypt_mode_r;

  cph_state_t state_r;
  cph_state_t state_cur;
  cph_state_t state_nxt;
  logic [7:0] result_byte;

  logic [7:0] out_byte_r;
  logic       out_valid_r;
  logic [7:0] skid_byte_r;
  logic       skid_valid_r;
  logic       push;
  logic       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_low_r    <= '0;
      key_a_high_r   <= '0;
      key_b_low_r    <= '0;
      key_b_high_r   <= '0;
      start_key_no_r <= '0;
      encrypt_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_A_LOW:    key_a_low_r    <= cfg_data;
        REG_KEY_A_HIGH:   key_a_high_r   <= cfg_data;
        REG_KEY_B_LOW:    key_b_low_r    <= cfg_data;
        REG_KEY_B_HIGH:   key_b_high_r   <= cfg_data;
        REG_START_KEY_NO: start_key_no_r <= cfg_data[KeyNoW-1:0];
        REG_ENCRYPT_MODE: encrypt_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_restart) begin
      state_cur.pos_a      = PosAStart;
      state_cur.pos_b      = PosBStart;
      state_cur.key_number = start_key_no_r;
      state_cur.swap_flag  = 1'b0;
    end else begin
      state_cur = state_r;
    end
  end

  absc_step u_step (
    .data_byte    (in_data_byte),
    .encrypt_mode (encrypt_mode_r),
    .key_a        ({key_a_high_r, key_a_low_r}),
    .key_b        ({key_b_high_r, key_b_low_r}),
    .cur          (state_cur),
    .result_byte  (result_byte),
    .nxt          (state_nxt)
  );

  assign in_ready  = ~skid_valid_r;
  assign push      = in_valid & in_ready;
  assign pop       = out_valid_r & out_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pos_a      <= PosAStart;
      state_r.pos_b      <= PosBStart;
      state_r.key_number <= '0;
      state_r.swap_flag  <= 1'b0;
    end else if (push) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (push && (!out_valid_r || (pop && !skid_valid_r))) begin
        out_valid_r <= 1'b1;
      end else if (push && pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b1;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (push && (!out_valid_r || (pop && !skid_valid_r))) begin
      out_byte_r <= result_byte;
    end else if (push && pop) begin
      out_byte_r  <= skid_byte_r;
      skid_byte_r <= result_byte;
    end else if (push) begin
      skid_byte_r <= result_byte;
    end else if (pop) begin
      out_byte_r <= skid_byte_r;
    end else begin
      out_byte_r <= out_byte_r;
    end
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head entry");

  a_stalled_push_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("item accepted behind a stalled result was lost");

  a_pos_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos_b <= 4'd13)
    else $error("key B position beyond its wrap bound");

  a_push_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
